### design/hvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_pkg
// constants, tables and helpers shared by the great-circle distance pipeline
// ----------------------------------------------------------------------------
package hvd_pkg;

   localparam int CORDIC_STAGES = 32;
   localparam int CW            = 34;
   localparam int ANG_W         = 31;
   localparam int SQ_BITS       = 31;
   localparam int SQ_IN_W       = 2 * SQ_BITS - 1;
   localparam int PIPE_DEPTH    = 2 * CORDIC_STAGES + SQ_BITS + 12;

   localparam logic [63:0] CONV_FULL = 64'hC90FDAA22168C234 / 64'd1800000000;
   localparam logic [16:0] CONV_LO   = CONV_FULL[16:0];
   localparam logic [15:0] CONV_HI   = CONV_FULL[32:17];

   localparam logic [32:0] FULL_TURN    = 33'd3600000000;
   localparam logic [31:0] HALF_TURN    = 32'd1800000000;
   localparam logic [30:0] QUARTER_TURN = 31'd900000000;
   localparam logic [30:0] HALF_TURN_31 = 31'd1800000000;

   localparam logic [30:0] ONE_Q30            = 31'd1073741824;
   localparam logic signed [33:0] ONE_Q30_S   = 34'sd1073741824;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [22:0] EARTH_RADIUS_M     = 23'd6371010;
   localparam logic [24:0] DIST_MAX           = 25'd20015119;

   localparam logic signed [CW-1:0] ATAN_HEAD [10] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149
   };

   // arctangent of 2^-idx in q30
   function automatic logic signed [CW-1:0] atan_entry(input int idx);
      logic signed [CW-1:0] r;
      r = '0;
      if (idx < 10) begin
         r = ATAN_HEAD[idx];
      end else if (idx <= 30) begin
         r[30-idx] = 1'b1;
      end
      return r;
   endfunction

endpackage

### design/hvd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd channel interfaces
// point-pair request channel and distance response channel
// ----------------------------------------------------------------------------
interface hvd_req_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] first_latitude;
   logic signed [31:0] first_longitude;
   logic signed [30:0] second_latitude;
   logic signed [31:0] second_longitude;

   modport source (output valid, first_latitude, first_longitude, second_latitude,
                   second_longitude, input ready);
   modport sink   (input valid, first_latitude, first_longitude, second_latitude,
                   second_longitude, output ready);
endinterface

interface hvd_rsp_if;
   logic        valid;
   logic        ready;
   logic [24:0] arc_meters;

   modport source (output valid, arc_meters, input ready);
   modport sink   (input valid, arc_meters, output ready);
endinterface

### design/haversine_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_top
// great-circle distance between two points, rounded to whole meters
//
// req_if carries one point pair per transfer (latitude, longitude in 1e-7
// degree); rsp_if returns one distance per pair, in order.
// the whole datapath is one pipeline: angle prep, four rotation cordics,
// the haversine products, two bit-serial-per-stage square roots and a
// vectoring cordic, one register stage per iteration.
// throughput: one pair per cycle unless a stall holds the pipeline, set by the
// fully unrolled cordic and square root stages.
// reset clears the valid bits of every stage; data registers are not reset.
// when the receiver holds rsp_if.ready low with a result waiting, the whole
// pipeline holds and req_if.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module haversine_distance_top (
   input  logic        clock,
   input  logic        reset,
   hvd_req_if.sink     req_if,
   hvd_rsp_if.source   rsp_if
);

   localparam int CS    = hvd_pkg::CORDIC_STAGES;
   localparam int IDX_A = 9 + CS;

   logic en;
   logic [hvd_pkg::PIPE_DEPTH-1:0] vld_ff;

   assign en           = !vld_ff[hvd_pkg::PIPE_DEPTH-1] || rsp_if.ready;
   assign req_if.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[hvd_pkg::PIPE_DEPTH-2:0], req_if.valid};
      end
   end

   // stage 1: input capture
   logic signed [30:0] lat1_ff, lat2_ff;
   logic signed [31:0] lng1_ff, lng2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lat1_ff <= req_if.first_latitude;
         lng1_ff <= req_if.first_longitude;
         lat2_ff <= req_if.second_latitude;
         lng2_ff <= req_if.second_longitude;
      end
   end

   // stage 2: differences and latitude magnitudes
   logic signed [31:0] dlat_ff;
   logic signed [32:0] dlng_ff;
   logic [30:0]        m2_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         dlat_ff  <= {lat1_ff[30], lat1_ff} - {lat2_ff[30], lat2_ff};
         dlng_ff  <= {lng1_ff[31], lng1_ff} - {lng2_ff[31], lng2_ff};
         m2_ff[0] <= lat1_ff[30] ? 31'(-lat1_ff) : 31'(lat1_ff);
         m2_ff[1] <= lat2_ff[30] ? 31'(-lat2_ff) : 31'(lat2_ff);
      end
   end

   // stage 3: difference magnitudes, latitude fold past 90 degrees
   logic [31:0] rl3_ff;
   logic [32:0] rn3_ff;
   logic [30:0] m3_ff [2];
   logic [1:0]  neg_ff [CS+5];

   always_ff @(posedge clock) begin
      if (en) begin
         rl3_ff <= dlat_ff[31] ? 32'(-dlat_ff) : 32'(dlat_ff);
         rn3_ff <= dlng_ff[32] ? 33'(-dlng_ff) : 33'(dlng_ff);
         for (int k = 0; k < 2; k++) begin
            if (m2_ff[k] > hvd_pkg::QUARTER_TURN) begin
               m3_ff[k]     <= hvd_pkg::HALF_TURN_31 - m2_ff[k];
               neg_ff[0][k] <= 1'b1;
            end else begin
               m3_ff[k]     <= m2_ff[k];
               neg_ff[0][k] <= 1'b0;
            end
         end
         for (int j = 1; j < CS + 5; j++) begin
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   // stage 4: longitude difference modulo a full turn
   logic [31:0] rl4_ff, rn4_ff;
   logic [30:0] m4_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         rl4_ff <= rl3_ff;
         rn4_ff <= (rn3_ff >= hvd_pkg::FULL_TURN) ? 32'(rn3_ff - hvd_pkg::FULL_TURN)
                                                 : rn3_ff[31:0];
         m4_ff  <= m3_ff;
      end
   end

   // stage 5: fold differences into [0, 180] degrees
   logic [30:0] r5_ff [4];
   logic [32:0] ful32;

   assign ful32 = hvd_pkg::FULL_TURN;

   always_ff @(posedge clock) begin
      if (en) begin
         r5_ff[0] <= (rl4_ff > hvd_pkg::HALF_TURN) ? 31'(ful32[31:0] - rl4_ff)
                                                  : rl4_ff[30:0];
         r5_ff[1] <= (rn4_ff > hvd_pkg::HALF_TURN) ? 31'(ful32[31:0] - rn4_ff)
                                                  : rn4_ff[30:0];
         r5_ff[2] <= m4_ff[0];
         r5_ff[3] <= m4_ff[1];
      end
   end

   // stage 6: degree to radian partial products
   logic [47:0] pl6_ff [4];
   logic [46:0] ph6_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            pl6_ff[k] <= {17'b0, r5_ff[k]} * {31'b0, hvd_pkg::CONV_LO};
            ph6_ff[k] <= {16'b0, r5_ff[k]} * {31'b0, hvd_pkg::CONV_HI};
         end
      end
   end

   // stage 7: sum and round to q30 angles
   logic [63:0] conv_sum [4];
   logic [30:0] ang7_ff  [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         conv_sum[k] = {16'b0, pl6_ff[k]} + ({17'b0, ph6_ff[k]} << 17)
                     + ((k < 2) ? (64'd1 << 32) : (64'd1 << 31));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang7_ff[0] <= conv_sum[0][63:33];
         ang7_ff[1] <= conv_sum[1][63:33];
         ang7_ff[2] <= conv_sum[2][62:32];
         ang7_ff[3] <= conv_sum[3][62:32];
      end
   end

   // sines of half differences, cosines of latitudes
   logic signed [hvd_pkg::CW-1:0] s1, s2, c1_raw, c2_raw;

   hvd_cordic_rot u_rot_dlat (
      .clock(clock), .en(en), .angle(ang7_ff[0]), .cos_out(), .sin_out(s1)
   );
   hvd_cordic_rot u_rot_dlng (
      .clock(clock), .en(en), .angle(ang7_ff[1]), .cos_out(), .sin_out(s2)
   );
   hvd_cordic_rot u_rot_lat1 (
      .clock(clock), .en(en), .angle(ang7_ff[2]), .cos_out(c1_raw), .sin_out()
   );
   hvd_cordic_rot u_rot_lat2 (
      .clock(clock), .en(en), .angle(ang7_ff[3]), .cos_out(c2_raw), .sin_out()
   );

   // squares and cosine product
   logic signed [hvd_pkg::CW-1:0]   c1, c2;
   logic signed [2*hvd_pkg::CW-1:0] pp, qq, cc;
   logic signed [32:0]              p_ff, q_ff, cc_ff;

   assign c1 = neg_ff[CS+4][0] ? -c1_raw : c1_raw;
   assign c2 = neg_ff[CS+4][1] ? -c2_raw : c2_raw;
   assign pp = s1 * s1 + (2*hvd_pkg::CW)'(64'sd536870912);
   assign qq = s2 * s2 + (2*hvd_pkg::CW)'(64'sd536870912);
   assign cc = c1 * c2 + (2*hvd_pkg::CW)'(64'sd536870912);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff  <= pp[62:30];
         q_ff  <= qq[62:30];
         cc_ff <= cc[62:30];
      end
   end

   // longitude term
   logic signed [65:0] qc;
   logic signed [32:0] p2_ff, qc_ff;

   assign qc = q_ff * cc_ff + 66'sd536870912;

   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff <= p_ff;
         qc_ff <= qc[62:30];
      end
   end

   // haversine term, saturated to [0, 1]
   logic signed [33:0] a_sum;
   logic [30:0]        a_ff;

   assign a_sum = {p2_ff[32], p2_ff} + {qc_ff[32], qc_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         if (a_sum[33]) begin
            a_ff <= '0;
         end else if (a_sum > hvd_pkg::ONE_Q30_S) begin
            a_ff <= hvd_pkg::ONE_Q30;
         end else begin
            a_ff <= a_sum[30:0];
         end
      end
   end

   // square roots of a and 1 - a
   logic [30:0] a_comp;
   logic [hvd_pkg::SQ_BITS-1:0] sqrt_a, sqrt_b;

   assign a_comp = hvd_pkg::ONE_Q30 - a_ff;

   hvd_isqrt u_sqrt_a (
      .clock(clock), .en(en), .value({a_ff, 30'b0}), .root(sqrt_a)
   );
   hvd_isqrt u_sqrt_b (
      .clock(clock), .en(en), .value({a_comp, 30'b0}), .root(sqrt_b)
   );

   // central half angle
   logic signed [hvd_pkg::CW-1:0] half_ang;

   hvd_cordic_vec u_vec (
      .clock(clock), .en(en), .y_start(sqrt_a), .x_start(sqrt_b), .angle_out(half_ang)
   );

   // scale by the sphere radius
   logic [33:0] ang;
   logic [56:0] dprod_ff;

   assign ang = half_ang[hvd_pkg::CW-1] ? 34'd0 : {half_ang[32:0], 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         dprod_ff <= {23'b0, ang} * {34'b0, hvd_pkg::EARTH_RADIUS_M};
      end
   end

   // round to meters and saturate
   logic [56:0] dsum;
   logic [26:0] dist_full;
   logic [24:0] dist_ff;

   assign dsum      = dprod_ff + (57'd1 << 29);
   assign dist_full = dsum[56:30];

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= (dist_full > {2'b0, hvd_pkg::DIST_MAX}) ? hvd_pkg::DIST_MAX
                                                           : dist_full[24:0];
      end
   end

   assign rsp_if.valid      = vld_ff[hvd_pkg::PIPE_DEPTH-1];
   assign rsp_if.arc_meters = dist_ff;

   // haversine term stays within [0, 1]
   a_in_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[IDX_A] |-> a_ff <= hvd_pkg::ONE_Q30)
      else $error("haversine term out of range");

   // distance stays within half the circumference
   dist_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.arc_meters <= hvd_pkg::DIST_MAX)
      else $error("distance above limit");

   // a stall freezes every stage
   stall_holds : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   // a request transfer enters the first stage
   req_enters : assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> vld_ff[0])
      else $error("request transfer lost");

endmodule

### design/hvd_cordic_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_cordic_rot
// unrolled rotation-mode cordic, one register stage per iteration
// ----------------------------------------------------------------------------
module hvd_cordic_rot (
   input  logic                            clock,
   input  logic                            en,
   input  logic [hvd_pkg::ANG_W-1:0]       angle,
   output logic signed [hvd_pkg::CW-1:0]   cos_out,
   output logic signed [hvd_pkg::CW-1:0]   sin_out
);

   logic signed [hvd_pkg::CW-1:0] x_ff [hvd_pkg::CORDIC_STAGES];
   logic signed [hvd_pkg::CW-1:0] y_ff [hvd_pkg::CORDIC_STAGES];
   logic signed [hvd_pkg::CW-1:0] z_ff [hvd_pkg::CORDIC_STAGES];

   for (genvar i = 0; i < hvd_pkg::CORDIC_STAGES; i++) begin : g_stage
      logic signed [hvd_pkg::CW-1:0] xp, yp, zp, x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign xp = hvd_pkg::CORDIC_GAIN;
         assign yp = '0;
         assign zp = signed'({{(hvd_pkg::CW-hvd_pkg::ANG_W){1'b0}}, angle});
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      always_comb begin
         if (!zp[hvd_pkg::CW-1]) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - hvd_pkg::atan_entry(i);
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + hvd_pkg::atan_entry(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign cos_out = x_ff[hvd_pkg::CORDIC_STAGES-1];
   assign sin_out = y_ff[hvd_pkg::CORDIC_STAGES-1];

endmodule

### design/hvd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_isqrt
// pipelined integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
module hvd_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [hvd_pkg::SQ_IN_W-1:0]   value,
   output logic [hvd_pkg::SQ_BITS-1:0]   root
);

   logic [hvd_pkg::SQ_IN_W-1:0] rem_ff  [hvd_pkg::SQ_BITS];
   logic [hvd_pkg::SQ_BITS-1:0] root_ff [hvd_pkg::SQ_BITS];

   for (genvar s = 0; s < hvd_pkg::SQ_BITS; s++) begin : g_stage
      localparam int K = hvd_pkg::SQ_BITS - 1 - s;
      logic [hvd_pkg::SQ_IN_W-1:0] remp, rem_in;
      logic [hvd_pkg::SQ_BITS-1:0] rp, root_in;
      logic [hvd_pkg::SQ_IN_W:0]   trial;

      if (s == 0) begin : g_first
         assign remp = value;
         assign rp   = '0;
      end else begin : g_next
         assign remp = rem_ff[s-1];
         assign rp   = root_ff[s-1];
      end

      // (root + 2^k)^2 - root^2
      assign trial = ({{hvd_pkg::SQ_BITS{1'b0}}, rp} << (K + 1))
                   | ((hvd_pkg::SQ_IN_W+1)'(1) << (2 * K));

      always_comb begin
         if ({1'b0, remp} >= trial) begin
            rem_in  = remp - trial[hvd_pkg::SQ_IN_W-1:0];
            root_in = rp | (hvd_pkg::SQ_BITS'(1) << K);
         end else begin
            rem_in  = remp;
            root_in = rp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign root = root_ff[hvd_pkg::SQ_BITS-1];

endmodule

### design/hvd_cordic_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_cordic_vec
// unrolled vectoring-mode cordic giving atan2(y, x) for x, y >= 0
// ----------------------------------------------------------------------------
module hvd_cordic_vec (
   input  logic                            clock,
   input  logic                            en,
   input  logic [hvd_pkg::SQ_BITS-1:0]     y_start,
   input  logic [hvd_pkg::SQ_BITS-1:0]     x_start,
   output logic signed [hvd_pkg::CW-1:0]   angle_out
);

   logic signed [hvd_pkg::CW-1:0] x_ff [hvd_pkg::CORDIC_STAGES];
   logic signed [hvd_pkg::CW-1:0] y_ff [hvd_pkg::CORDIC_STAGES];
   logic signed [hvd_pkg::CW-1:0] z_ff [hvd_pkg::CORDIC_STAGES];

   for (genvar i = 0; i < hvd_pkg::CORDIC_STAGES; i++) begin : g_stage
      logic signed [hvd_pkg::CW-1:0] xp, yp, zp, x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign xp = signed'({{(hvd_pkg::CW-hvd_pkg::SQ_BITS){1'b0}}, x_start});
         assign yp = signed'({{(hvd_pkg::CW-hvd_pkg::SQ_BITS){1'b0}}, y_start});
         assign zp = '0;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      always_comb begin
         if (!yp[hvd_pkg::CW-1]) begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + hvd_pkg::atan_entry(i);
         end else begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - hvd_pkg::atan_entry(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign angle_out = z_ff[hvd_pkg::CORDIC_STAGES-1];

endmodule
